// ===== hw/rtl/preemptive_priority_scheduler_unit_macros.svh =====
// Assertion macros for the scheduler RTL.
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_UNIT_MACROS_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define PPS_ASSERT_NOW(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pps assertion failed");
// Next-cycle implication.
`define PPS_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pps assertion failed");
`else
`define PPS_ASSERT_NOW(name, clk, rst, ante, cons)
`define PPS_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

// ===== hw/rtl/pps_pkg.sv =====
// Shared types and constants of the priority scheduler.
package pps_pkg;

  localparam int MAX_TASKS = 16;
  localparam int SLOT_W    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);
  localparam int TIME_W    = 16;
  localparam int TID_W     = 4;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [TIME_W-1:0] time_t;
  typedef logic [TID_W-1:0]  tid_t;

  localparam cnt_t  MAX_CNT  = cnt_t'(MAX_TASKS);
  localparam time_t TIME_MAX = '1;

  // Command codes
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_ADDED = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RUN   = 2'd2,
    STAT_IDLE  = 2'd3
  } status_e;

  // One task record as stored in the task RAM
  typedef struct packed {
    time_t      arrival;
    time_t      burst;
    logic [7:0] prio;
    time_t      remaining;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

endpackage

// ===== hw/rtl/pps_req_if.sv =====
// Command channel: one add or tick item per handshake.
interface pps_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [15:0] arrival_time;
  logic [15:0] burst_length;
  logic [7:0]  priority_req;

  modport source (output valid, cmd, arrival_time, burst_length, priority_req, input ready);
  modport sink   (input valid, cmd, arrival_time, burst_length, priority_req, output ready);
endinterface

// ===== hw/rtl/pps_rsp_if.sv =====
// Result channel: one result item per command.
interface pps_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] slot_time;
  logic [3:0]  task_id;
  logic        finished;
  logic [15:0] completion_time;
  logic [15:0] turnaround_time;
  logic [15:0] waiting_time;

  modport source (output valid, status, slot_time, task_id, finished, completion_time,
                  turnaround_time, waiting_time, input ready);
  modport sink   (input valid, status, slot_time, task_id, finished, completion_time,
                  turnaround_time, waiting_time, output ready);
endinterface

// ===== hw/rtl/pps_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module pps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/preemptive_priority_scheduler_unit.sv =====
// Preemptive priority scheduler: task table in RAM, sequential slot scan per tick.
//
// Usage:
//   req carries one command item: add (cmd 0) stores a task in the next free
//   slot, tick (cmd 1) runs the ready task with the smallest priority number
//   (lowest slot wins ties) for one time unit. rsp returns exactly one result
//   item per command, in order.
// Sequencing:
//   add:  accepted in ST_IDLE, then ST_OUT loads the result into the output register.
//   tick: accepted in ST_IDLE, then ST_SCAN reads each stored slot, ST_DRAIN checks
//         the last read, ST_UPDATE forms the result and ST_OUT loads it; ST_SCAN and
//         ST_DRAIN are skipped when the table is empty. The task RAM is read one
//         slot per cycle during the scan, so its single read port sets the scan length.
//   A new item is taken once the previous one has been handed to the output
//   register, even if that result is still waiting on rsp.
// Reset (rst, synchronous): clears time, task count and done flags; task RAM
//   contents are not cleared, only slots below the count are ever read.
// Stall: while rsp.ready is low the output register holds its item; a
//   following result waits in the core and req stays not ready meanwhile.
module preemptive_priority_scheduler_unit (
  input logic clk,
  input logic rst,
  pps_req_if.sink   req,
  pps_rsp_if.source rsp
);

  `include "preemptive_priority_scheduler_unit_macros.svh"

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE,
    ST_OUT
  } state_t;

  state_t                   state;
  pps_pkg::cnt_t            task_count;
  pps_pkg::time_t           current_time;
  logic [pps_pkg::MAX_TASKS-1:0] done_flags;

  // Scan bookkeeping
  pps_pkg::slot_t           scan_idx;
  pps_pkg::slot_t           chk_slot;
  logic                     chk_vld;
  pps_pkg::time_t           start;
  logic                     found;
  pps_pkg::slot_t           best_slot;
  pps_pkg::rec_t            best_rec;

  // Pending result
  pps_pkg::status_e         res_status;
  pps_pkg::time_t           res_slot_time;
  pps_pkg::tid_t            res_task_id;
  logic                     res_finished;
  pps_pkg::time_t           res_comp;
  pps_pkg::time_t           res_tat;
  pps_pkg::time_t           res_wt;

  // Output register
  logic                     rsp_valid;
  pps_pkg::status_e         rsp_status;
  pps_pkg::time_t           rsp_slot_time;
  pps_pkg::tid_t            rsp_task_id;
  logic                     rsp_finished;
  pps_pkg::time_t           rsp_comp;
  pps_pkg::time_t           rsp_tat;
  pps_pkg::time_t           rsp_wt;

  // RAM ports
  logic                     ram_we;
  pps_pkg::slot_t           ram_waddr;
  pps_pkg::rec_t            ram_wdata;
  pps_pkg::rec_t            ram_rdata;
  logic [pps_pkg::REC_W-1:0] ram_rbits;

  logic                     req_fire;
  logic                     rsp_load;
  logic                     table_full;
  logic                     last_issue;
  logic                     eligible;
  logic                     take;
  logic                     best_last;
  pps_pkg::time_t           tat;
  pps_pkg::time_t           wt;
  pps_pkg::time_t           rem_next;
  pps_pkg::time_t           time_inc;

  pps_pkg::rec_t            add_rec;

  assign req.ready  = (state == ST_IDLE);
  assign req_fire   = req.valid && req.ready;
  assign rsp_load   = (state == ST_OUT) && (!rsp_valid || rsp.ready);
  assign table_full = (task_count == pps_pkg::MAX_CNT);
  assign last_issue = ((pps_pkg::cnt_t'(scan_idx) + pps_pkg::cnt_t'(1)) == task_count);
  assign time_inc   = (current_time == pps_pkg::TIME_MAX) ? current_time
                                                          : current_time + 16'd1;

  // Candidate check on the record read last cycle
  assign ram_rdata = pps_pkg::rec_t'(ram_rbits);
  assign eligible  = chk_vld && !done_flags[chk_slot] && (ram_rdata.arrival <= start);
  assign take      = eligible && (!found || (ram_rdata.prio < best_rec.prio));

  // Completion figures; current_time already holds the tick end time
  assign best_last = (best_rec.remaining <= 16'd1);
  assign tat       = current_time - best_rec.arrival;
  assign wt        = (tat >= best_rec.burst) ? (tat - best_rec.burst) : '0;
  assign rem_next  = best_last ? '0 : (best_rec.remaining - 16'd1);

  // RAM write: new task on add, remaining count on a run tick
  always_comb begin
    add_rec.arrival   = req.arrival_time;
    add_rec.burst     = req.burst_length;
    add_rec.prio      = req.priority_req;
    add_rec.remaining = req.burst_length;
    ram_we    = 1'b0;
    ram_waddr = best_slot;
    ram_wdata = add_rec;
    if (req_fire && (req.cmd == pps_pkg::CMD_ADD) && !table_full) begin
      ram_we    = 1'b1;
      ram_waddr = task_count[pps_pkg::SLOT_W-1:0];
    end else if ((state == ST_UPDATE) && found) begin
      ram_we    = 1'b1;
      ram_wdata = best_rec;
      ram_wdata.remaining = rem_next;
    end
  end

  pps_ram #(
    .WIDTH (pps_pkg::REC_W),
    .DEPTH (pps_pkg::MAX_TASKS)
  ) u_task_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_idx),
    .rdata (ram_rbits)
  );

  // Sequencer, scan state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      task_count   <= '0;
      current_time <= '0;
      done_flags   <= '0;
      chk_vld      <= 1'b0;
      found        <= 1'b0;
      rsp_valid    <= 1'b0;
    end else begin
      // Read data of a scan slot is checked in the cycle after its address
      chk_vld <= (state == ST_SCAN);

      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end

      // Keep the best candidate seen so far
      if (take) begin
        found     <= 1'b1;
        best_slot <= chk_slot;
        best_rec  <= ram_rdata;
      end

      case (state)
        ST_IDLE: begin
          if (req_fire) begin
            if (req.cmd == pps_pkg::CMD_ADD) begin
              res_slot_time <= current_time;
              res_finished  <= 1'b0;
              res_comp      <= '0;
              res_tat       <= '0;
              res_wt        <= '0;
              if (table_full) begin
                res_status  <= pps_pkg::STAT_FULL;
                res_task_id <= '0;
              end else begin
                res_status  <= pps_pkg::STAT_ADDED;
                res_task_id <= pps_pkg::tid_t'(task_count[pps_pkg::SLOT_W-1:0]);
                done_flags[task_count[pps_pkg::SLOT_W-1:0]] <= 1'b0;
                task_count  <= task_count + pps_pkg::cnt_t'(1);
              end
              state <= ST_OUT;
            end else begin
              start        <= current_time;
              current_time <= time_inc;
              found        <= 1'b0;
              scan_idx     <= '0;
              state        <= (task_count == '0) ? ST_UPDATE : ST_SCAN;
            end
          end
        end

        ST_SCAN: begin
          chk_slot <= scan_idx;
          if (last_issue) begin
            state <= ST_DRAIN;
          end else begin
            scan_idx <= scan_idx + pps_pkg::slot_t'(1);
          end
        end

        ST_DRAIN: begin
          state <= ST_UPDATE;
        end

        ST_UPDATE: begin
          res_slot_time <= start;
          if (found) begin
            res_status   <= pps_pkg::STAT_RUN;
            res_task_id  <= pps_pkg::tid_t'(best_slot);
            res_finished <= best_last;
            res_comp     <= best_last ? current_time : '0;
            res_tat      <= best_last ? tat : '0;
            res_wt       <= best_last ? wt : '0;
            if (best_last) begin
              done_flags[best_slot] <= 1'b1;
            end
          end else begin
            res_status   <= pps_pkg::STAT_IDLE;
            res_task_id  <= '0;
            res_finished <= 1'b0;
            res_comp     <= '0;
            res_tat      <= '0;
            res_wt       <= '0;
          end
          state <= ST_OUT;
        end

        ST_OUT: begin
          if (rsp_load) begin
            rsp_status    <= res_status;
            rsp_slot_time <= res_slot_time;
            rsp_task_id   <= res_task_id;
            rsp_finished  <= res_finished;
            rsp_comp      <= res_comp;
            rsp_tat       <= res_tat;
            rsp_wt        <= res_wt;
            state         <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid           = rsp_valid;
  assign rsp.status          = rsp_status;
  assign rsp.slot_time       = rsp_slot_time;
  assign rsp.task_id         = rsp_task_id;
  assign rsp.finished        = rsp_finished;
  assign rsp.completion_time = rsp_comp;
  assign rsp.turnaround_time = rsp_tat;
  assign rsp.waiting_time    = rsp_wt;

  // Checks
  `PPS_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, task_count <= pps_pkg::MAX_CNT)
  `PPS_ASSERT_NOW(a_no_write_in_scan, clk, rst, ram_we,
                  (state == ST_IDLE) || (state == ST_UPDATE))
  `PPS_ASSERT_NOW(a_best_in_table, clk, rst, (state == ST_UPDATE) && found,
                  pps_pkg::cnt_t'(best_slot) < task_count)
  `PPS_ASSERT_NEXT(a_tick_leaves_idle, clk, rst,
                   req_fire && (req.cmd == pps_pkg::CMD_TICK), state != ST_IDLE)
  `PPS_ASSERT_NOW(a_finish_only_on_run, clk, rst, rsp_valid && rsp_finished,
                  rsp_status == pps_pkg::STAT_RUN)

endmodule

// ===== tb/sv/tb_preemptive_priority_scheduler_unit.sv =====
`timescale 1ns / 1ps
// Testbench for the priority scheduler: directed and random command streams.
module tb_preemptive_priority_scheduler_unit;

  localparam int    RANDOM_ITEMS  = 1930;
  localparam int    SETTLE_CYCLES = 40;
  localparam int    LIMIT_NS      = 40_000_000;

  typedef struct {
    pps_pkg::status_e status;
    pps_pkg::time_t   slot_time;
    pps_pkg::tid_t    task_id;
    logic             finished;
    pps_pkg::time_t   completion;
    pps_pkg::time_t   turnaround;
    pps_pkg::time_t   waiting;
  } sched_result_t;

  logic clk;
  logic rst = 1'b1;

  pps_req_if req ();
  pps_rsp_if rsp ();

  preemptive_priority_scheduler_unit dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  // Local copy of the task table and clock
  pps_pkg::time_t task_arrival [pps_pkg::MAX_TASKS];
  pps_pkg::time_t task_burst   [pps_pkg::MAX_TASKS];
  logic [7:0]     task_prio    [pps_pkg::MAX_TASKS];
  pps_pkg::time_t task_left    [pps_pkg::MAX_TASKS];
  logic           task_done    [pps_pkg::MAX_TASKS];
  int             task_total;
  pps_pkg::time_t sched_now;

  sched_result_t pending_results [$];
  int            error_count;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Predict the result of one command and update the local table
  function automatic sched_result_t schedule_command(logic cmd, pps_pkg::time_t arr,
                                                     pps_pkg::time_t bur, logic [7:0] pri);
    sched_result_t  res;
    int             pick;
    pps_pkg::time_t start;
    res = '{pps_pkg::STAT_ADDED, sched_now, '0, 1'b0, '0, '0, '0};
    if (cmd == pps_pkg::CMD_ADD) begin
      if (task_total >= pps_pkg::MAX_TASKS) begin
        res.status = pps_pkg::STAT_FULL;
      end else begin
        task_arrival[task_total] = arr;
        task_burst[task_total]   = bur;
        task_prio[task_total]    = pri;
        task_left[task_total]    = bur;
        task_done[task_total]    = 1'b0;
        res.task_id = pps_pkg::tid_t'(task_total);
        task_total++;
      end
      return res;
    end

    // Tick: lowest priority number among ready tasks, lowest slot on ties
    start = sched_now;
    pick  = -1;
    for (int i = 0; i < task_total; i++) begin
      if (!task_done[i] && task_arrival[i] <= start &&
          (pick < 0 || task_prio[i] < task_prio[pick])) begin
        pick = i;
      end
    end
    if (sched_now != pps_pkg::TIME_MAX) sched_now++;
    res.slot_time = start;
    if (pick < 0) begin
      res.status = pps_pkg::STAT_IDLE;
      return res;
    end
    res.status  = pps_pkg::STAT_RUN;
    res.task_id = pps_pkg::tid_t'(pick);
    if (task_left[pick] <= 1) begin
      task_left[pick]  = '0;
      task_done[pick]  = 1'b1;
      res.finished     = 1'b1;
      res.completion   = sched_now;
      res.turnaround   = sched_now - task_arrival[pick];
      // saturated time can leave turnaround below the burst
      res.waiting      = (res.turnaround >= task_burst[pick]) ?
                         res.turnaround - task_burst[pick] : '0;
    end else begin
      task_left[pick]--;
    end
    return res;
  endfunction

  // Drive one command item, wait for it to be taken, record its expected result
  task automatic send_command(logic cmd, pps_pkg::time_t arr, pps_pkg::time_t bur,
                              logic [7:0] pri);
    int gap;
    gap = $urandom_range(0, 19);
    @(negedge clk);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.valid        <= 1'b1;
    req.cmd          <= cmd;
    req.arrival_time <= arr;
    req.burst_length <= bur;
    req.priority_req <= pri;
    do @(posedge clk); while (req.ready !== 1'b1);
    pending_results.push_back(schedule_command(cmd, arr, bur, pri));
  endtask

  task automatic add_task(pps_pkg::time_t arr, pps_pkg::time_t bur, logic [7:0] pri);
    send_command(pps_pkg::CMD_ADD, arr, bur, pri);
  endtask

  // Data fields are don't-care on a tick; fill them with noise
  task automatic run_tick();
    send_command(pps_pkg::CMD_TICK, pps_pkg::time_t'($urandom), pps_pkg::time_t'($urandom),
                 8'($urandom));
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  // Result side: random backpressure and in-order comparison
  initial begin : result_monitor
    sched_result_t want;
    int            stall;
    rsp.ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      stall = $urandom_range(0, 19);
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (rsp.valid !== 1'b1);
      if (pending_results.size() == 0) begin
        $error("result item with no command outstanding: status %0d", rsp.status);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 16'(want.status), 16'(rsp.status));
        check_field("slot_time", want.slot_time, rsp.slot_time);
        check_field("task_id", 16'(want.task_id), 16'(rsp.task_id));
        check_field("finished", 16'(want.finished), 16'(rsp.finished));
        check_field("completion_time", want.completion, rsp.completion_time);
        check_field("turnaround_time", want.turnaround, rsp.turnaround_time);
        check_field("waiting_time", want.waiting, rsp.waiting_time);
      end
    end
  end

  task automatic reset_block();
    task_total = 0;
    sched_now  = '0;
    for (int i = 0; i < pps_pkg::MAX_TASKS; i++) task_done[i] = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  endtask

  // Hand-picked schedule: idle on empty table, ties, zero burst, preemption
  task automatic test_directed_schedule();
    run_tick();
    add_task(16'd0, 16'd2, 8'd5);
    add_task(16'd1, 16'd1, 8'd5);
    add_task(16'd3, 16'd0, 8'd0);
    // extreme entry: arrives far in the future, never becomes ready
    add_task(pps_pkg::TIME_MAX, pps_pkg::TIME_MAX, 8'hFF);
    repeat (6) run_tick();
    add_task(16'd9, 16'd4, 8'd10);
    add_task(16'd10, 16'd2, 8'd3);
    repeat (9) run_tick();
  endtask

  // Mostly ticks with scattered adds; the table fills and adds are then refused
  task automatic test_random_mix();
    int             base;
    bit             do_add;
    pps_pkg::time_t arr;
    pps_pkg::time_t bur;
    logic [7:0]     pri;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (task_total < pps_pkg::MAX_TASKS) do_add = $urandom_range(0, 59) == 0;
      else do_add = $urandom_range(0, 14) == 0;
      if (!do_add) begin
        run_tick();
      end else begin
        case ($urandom_range(0, 7))
          0: arr = pps_pkg::time_t'($urandom);
          1: arr = pps_pkg::TIME_MAX - pps_pkg::time_t'($urandom_range(0, 20));
          default: begin
            base = int'(sched_now) + $urandom_range(0, 80) - 20;
            arr  = (base < 0) ? '0 :
                   (base > int'(pps_pkg::TIME_MAX)) ? pps_pkg::TIME_MAX :
                   pps_pkg::time_t'(base);
          end
        endcase
        pri = $urandom_range(0, 1) ? 8'($urandom_range(0, 7)) : 8'($urandom);
        case ($urandom_range(0, 7))
          0: bur = '0;
          1: begin
            bur = pps_pkg::time_t'($urandom);
            pri = 8'($urandom_range(128, 255));
          end
          default: bur = pps_pkg::time_t'($urandom_range(1, 40));
        endcase
        add_task(arr, bur, pri);
      end
    end
  endtask

  task automatic finish_run();
    @(negedge clk);
    req.valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    req.valid        = 1'b0;
    req.cmd          = pps_pkg::CMD_TICK;
    req.arrival_time = '0;
    req.burst_length = '0;
    req.priority_req = '0;
    error_count      = 0;
    reset_block();
    test_directed_schedule();
    test_random_mix();
    finish_run();
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(LIMIT_NS);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
